@@ rtl/spi_pkg.sv @@
// Shared types, widths and codes for the segment against plane crossing block.
package spi_pkg;

  // coordinate and register widths
  localparam int CW     = 32;
  localparam int LIM_W  = 17;
  localparam int LIM2_W = 34;

  // plane value, plane value difference and squared length widths
  localparam int PV_W  = 67;
  localparam int NV_W  = 68;
  localparam int L2_W  = 66;

  // parallel test: |N| is squared from two limbs, L2 is scaled in two limbs
  localparam int NSPLIT  = 25;
  localparam int L2SPLIT = 33;
  localparam int PL_W    = L2SPLIT + LIM2_W;
  localparam int SQ_W    = 4 * NSPLIT;

  // queue between classifier and divider
  localparam int QDEPTH = 4;

  // register indexes
  localparam logic [2:0] REG_PLANE_A   = 3'd0;
  localparam logic [2:0] REG_PLANE_B   = 3'd1;
  localparam logic [2:0] REG_PLANE_C   = 3'd2;
  localparam logic [2:0] REG_PLANE_D   = 3'd3;
  localparam logic [2:0] REG_PAR_LIMIT = 3'd4;

  typedef enum logic [1:0] {
    ST_HIT      = 2'd0,
    ST_SIDE     = 2'd1,
    ST_PARALLEL = 2'd2
  } status_t;

  typedef struct packed {
    logic signed [CW-1:0] start_x;
    logic signed [CW-1:0] start_y;
    logic signed [CW-1:0] start_z;
    logic signed [CW-1:0] end_x;
    logic signed [CW-1:0] end_y;
    logic signed [CW-1:0] end_z;
  } seg_t;

  typedef struct packed {
    logic [1:0]           status;
    logic signed [CW-1:0] hit_x;
    logic signed [CW-1:0] hit_y;
    logic signed [CW-1:0] hit_z;
  } res_t;

  typedef struct packed {
    logic signed [CW-1:0] a;
    logic signed [CW-1:0] b;
    logic signed [CW-1:0] c;
    logic signed [CW-1:0] d;
    logic [LIM2_W-1:0]    lim2;
  } plane_cfg_t;

  // classified segment handed from the front to the divider
  typedef struct packed {
    status_t                status;
    logic [2:0][CW-1:0]     start;
    logic [2:0][CW-1:0]     dmag;
    logic [2:0]             dneg;
    logic [PV_W-1:0]        mag1;
    logic [NV_W-1:0]        nmag;
  } job_t;

endpackage

@@ rtl/spi_if.sv @@
// Valid/ready channel interfaces for segment words and result words.
interface spi_seg_if;
  logic          valid;
  logic          ready;
  spi_pkg::seg_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface spi_res_if;
  logic          valid;
  logic          ready;
  spi_pkg::res_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ rtl/spi_front.sv @@
// Front pipeline: plane values, direction, squared terms and classification.
module spi_front #(
  parameter int FRAC_BITS = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  spi_pkg::plane_cfg_t cfg,
  input  logic                in_valid,
  output logic                in_ready,
  input  spi_pkg::seg_t       in_data,
  output logic                job_valid,
  input  logic                job_ready,
  output spi_pkg::job_t       job
);
  import spi_pkg::*;

  logic       en;
  logic [4:0] vld;

  // stage one: products and direction
  logic signed [CW-1:0]   sv [3];
  logic signed [CW-1:0]   ev [3];
  logic signed [CW-1:0]   cf [3];
  logic [CW:0]            dd [3];
  logic signed [2*CW-1:0] ps_next [3];
  logic signed [2*CW-1:0] pe_next [3];
  logic [CW-1:0]          dm_next [3];
  logic [2:0]             dn_next;
  logic signed [2*CW-1:0] ps1 [3];
  logic signed [2*CW-1:0] pe1 [3];
  logic [2:0][CW-1:0]     s1;
  logic [CW-1:0]          dm1 [3];
  logic [2:0]             dn1;

  // stage two: plane values and squares
  logic signed [PV_W-1:0] dterm;
  logic signed [PV_W-1:0] p1_next, p2_next;
  logic [2*CW-1:0]        sq_next [3];
  logic signed [PV_W-1:0] p1_2, p2_2;
  logic [2*CW-1:0]        sq2 [3];
  logic [2:0][CW-1:0]     s2;
  logic [2:0][CW-1:0]     dm2;
  logic [2:0]             dn2;

  // stage three: difference, length and side test
  logic signed [NV_W-1:0] n3;
  logic [L2_W-1:0]        l2_3;
  logic                   side3;
  logic [PV_W-1:0]        mag1_3;
  logic [2:0][CW-1:0]     s3;
  logic [2:0][CW-1:0]     dm3;
  logic [2:0]             dn3;

  // stage four: limb products for the parallel test
  logic [NV_W-1:0]        nmag_next;
  logic [NV_W-1:0]        nmag4;
  logic [2*NSPLIT-1:0]    ll4, lh4, hh4;
  logic [PL_W-1:0]        pl_lo4, pl_hi4;
  logic                   big4, nzero4, l2zero4, side4;
  logic [PV_W-1:0]        mag1_4;
  logic [2:0][CW-1:0]     s4;
  logic [2:0][CW-1:0]     dm4;
  logic [2:0]             dn4;

  // stage five: compare and classify
  logic [SQ_W-1:0]        nsq;
  logic [SQ_W:0]          rhs;
  status_t                st_next;

  assign en        = !vld[4] || job_ready;
  assign in_ready  = en;
  assign job_valid = vld[4];

  // split the segment, form the plane products, take the direction and its magnitude
  always_comb begin
    sv[0] = in_data.start_x;
    sv[1] = in_data.start_y;
    sv[2] = in_data.start_z;
    ev[0] = in_data.end_x;
    ev[1] = in_data.end_y;
    ev[2] = in_data.end_z;
    cf[0] = cfg.a;
    cf[1] = cfg.b;
    cf[2] = cfg.c;
    for (int k = 0; k < 3; k++) begin
      dd[k]      = {ev[k][CW-1], ev[k]} - {sv[k][CW-1], sv[k]};
      dn_next[k] = dd[k][CW];
      dm_next[k] = dd[k][CW] ? CW'(-dd[k]) : dd[k][CW-1:0];
      ps_next[k] = cf[k] * sv[k];
      pe_next[k] = cf[k] * ev[k];
    end
  end

  // sum the plane value at both ends and square the direction
  always_comb begin
    dterm   = PV_W'(cfg.d) <<< FRAC_BITS;
    p1_next = PV_W'(ps1[0]) + PV_W'(ps1[1]) + PV_W'(ps1[2]) + dterm;
    p2_next = PV_W'(pe1[0]) + PV_W'(pe1[1]) + PV_W'(pe1[2]) + dterm;
    for (int k = 0; k < 3; k++) begin
      sq_next[k] = (2*CW)'(dm1[k]) * (2*CW)'(dm1[k]);
    end
  end

  // magnitude of the plane value difference
  assign nmag_next = n3[NV_W-1] ? NV_W'(-n3) : NV_W'(n3);

  // finish the exact parallel test and pick the status
  always_comb begin
    nsq = (SQ_W'(hh4) << (2*NSPLIT)) + (SQ_W'(lh4) << (NSPLIT+1)) + SQ_W'(ll4);
    rhs = ((SQ_W+1)'(pl_hi4) << L2SPLIT) + (SQ_W+1)'(pl_lo4);
    if (side4) begin
      st_next = ST_SIDE;
    end else if (nzero4 || l2zero4) begin
      st_next = ST_PARALLEL;
    end else if (!big4 && ({1'b0, nsq} < rhs)) begin
      st_next = ST_PARALLEL;
    end else begin
      st_next = ST_HIT;
    end
  end

  // advance valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[3:0], in_valid};
    end
  end

  // advance payload
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        ps1[k] <= ps_next[k];
        pe1[k] <= pe_next[k];
        s1[k]  <= sv[k];
        dm1[k] <= dm_next[k];
        sq2[k] <= sq_next[k];
        dm2[k] <= dm1[k];
      end
      dn1 <= dn_next;

      p1_2 <= p1_next;
      p2_2 <= p2_next;
      s2   <= s1;
      dn2  <= dn1;

      n3     <= NV_W'(p2_2) - NV_W'(p1_2);
      l2_3   <= L2_W'(sq2[0]) + L2_W'(sq2[1]) + L2_W'(sq2[2]);
      side3  <= (!p1_2[PV_W-1] && (p1_2 != '0) && !p2_2[PV_W-1] && (p2_2 != '0)) ||
                (p1_2[PV_W-1] && p2_2[PV_W-1]);
      mag1_3 <= p1_2[PV_W-1] ? PV_W'(-p1_2) : PV_W'(p1_2);
      s3     <= s2;
      dm3    <= dm2;
      dn3    <= dn2;

      nmag4   <= nmag_next;
      big4    <= |nmag_next[NV_W-1:2*NSPLIT];
      ll4     <= (2*NSPLIT)'(nmag_next[NSPLIT-1:0]) * (2*NSPLIT)'(nmag_next[NSPLIT-1:0]);
      lh4     <= (2*NSPLIT)'(nmag_next[NSPLIT-1:0]) *
                 (2*NSPLIT)'(nmag_next[2*NSPLIT-1:NSPLIT]);
      hh4     <= (2*NSPLIT)'(nmag_next[2*NSPLIT-1:NSPLIT]) *
                 (2*NSPLIT)'(nmag_next[2*NSPLIT-1:NSPLIT]);
      pl_lo4  <= PL_W'(l2_3[L2SPLIT-1:0]) * PL_W'(cfg.lim2);
      pl_hi4  <= PL_W'(l2_3[L2_W-1:L2SPLIT]) * PL_W'(cfg.lim2);
      nzero4  <= (n3 == '0);
      l2zero4 <= (l2_3 == '0);
      side4   <= side3;
      mag1_4  <= mag1_3;
      s4      <= s3;
      dm4     <= dm3;
      dn4     <= dn3;

      job.status <= st_next;
      job.start  <= s4;
      job.dmag   <= dm4;
      job.dneg   <= dn4;
      job.mag1   <= mag1_4;
      job.nmag   <= nmag4;
    end
  end

endmodule

@@ rtl/spi_queue.sv @@
// Short word queue between the classifier and the divider.
module spi_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push_valid,
  output logic          push_ready,
  input  spi_pkg::job_t push_data,
  output logic          pop_valid,
  input  logic          pop_ready,
  output spi_pkg::job_t pop_data
);
  import spi_pkg::*;

  localparam int AW = $clog2(QDEPTH);

  job_t          store [QDEPTH];
  logic [AW-1:0] wr_ptr, rd_ptr;
  logic [AW:0]   count;
  logic          push, pop;

  assign push_ready = (count != (AW+1)'(QDEPTH));
  assign pop_valid  = (count != '0);
  assign pop_data   = store[rd_ptr];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  // track pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + AW'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + AW'(1);
      end
      if (push && !pop) begin
        count <= count + (AW+1)'(1);
      end else if (pop && !push) begin
        count <= count - (AW+1)'(1);
      end
    end
  end

  // hold the word
  always_ff @(posedge clk) begin
    if (push) begin
      store[wr_ptr] <= push_data;
    end
  end

endmodule

@@ rtl/spi_back.sv @@
// Back pipeline: one quotient digit per stage for each axis, then offset and clamp.
module spi_back (
  input  logic          clk,
  input  logic          rst,
  input  logic          job_valid,
  output logic          job_ready,
  input  spi_pkg::job_t job,
  output logic          res_valid,
  input  logic          res_ready,
  output spi_pkg::res_t res
);
  import spi_pkg::*;

  localparam int STEPS = CW;

  typedef struct packed {
    job_t                 job;
    logic [2:0][NV_W-1:0] rem;
    logic [2:0][CW-1:0]   quo;
  } div_stage_t;

  logic             en;
  logic [STEPS:0]   vld;
  div_stage_t       stg [STEPS+1];
  div_stage_t       nxt [STEPS+1];
  div_stage_t       load;
  res_t             res_next;
  logic [CW+1:0]    hv [3];
  logic [CW-1:0]    hc [3];

  // one digit of mag1 * dmag / nmag, digit in 0..2 since rem stays below nmag
  function automatic div_stage_t div_step(input div_stage_t x, input logic [2:0] dbits);
    div_stage_t      y;
    logic [NV_W+1:0] t, n1, n2;
    y  = x;
    n1 = {2'b00, x.job.nmag};
    n2 = {1'b0, x.job.nmag, 1'b0};
    for (int k = 0; k < 3; k++) begin
      t = {1'b0, x.rem[k], 1'b0} + (dbits[k] ? (NV_W+2)'(x.job.mag1) : '0);
      if (t >= n2) begin
        y.rem[k] = NV_W'(t - n2);
        y.quo[k] = {x.quo[k][CW-2:0], 1'b0} + CW'(2);
      end else if (t >= n1) begin
        y.rem[k] = NV_W'(t - n1);
        y.quo[k] = {x.quo[k][CW-2:0], 1'b0} + CW'(1);
      end else begin
        y.rem[k] = NV_W'(t);
        y.quo[k] = {x.quo[k][CW-2:0], 1'b0};
      end
    end
    return y;
  endfunction

  assign en        = !res_valid || res_ready;
  assign job_ready = en;

  // start each axis with empty remainder and quotient
  always_comb begin
    load     = '0;
    load.job = job;
  end
  assign nxt[0] = load;

  // one divider step per stage, most significant direction bit first
  for (genvar i = 0; i < STEPS; i++) begin : g_step
    assign nxt[i+1] = div_step(stg[i], {stg[i].job.dmag[2][STEPS-1-i],
                                        stg[i].job.dmag[1][STEPS-1-i],
                                        stg[i].job.dmag[0][STEPS-1-i]});
  end

  // apply the signed offset to the start point and clamp to the coordinate range
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      hv[k] = (CW+2)'($signed(stg[STEPS].job.start[k])) +
              (stg[STEPS].job.dneg[k] ? (CW+2)'(-(CW+2)'(stg[STEPS].quo[k]))
                                      : (CW+2)'(stg[STEPS].quo[k]));
      if (hv[k][CW+1:CW-1] == 3'b000 || hv[k][CW+1:CW-1] == 3'b111) begin
        hc[k] = hv[k][CW-1:0];
      end else if (hv[k][CW+1]) begin
        hc[k] = {1'b1, {(CW-1){1'b0}}};
      end else begin
        hc[k] = {1'b0, {(CW-1){1'b1}}};
      end
    end
    res_next.status = stg[STEPS].job.status;
    if (stg[STEPS].job.status == ST_HIT) begin
      res_next.hit_x = hc[0];
      res_next.hit_y = hc[1];
      res_next.hit_z = hc[2];
    end else begin
      res_next.hit_x = '0;
      res_next.hit_y = '0;
      res_next.hit_z = '0;
    end
  end

  // advance valid bits and the output flag
  always_ff @(posedge clk) begin
    if (rst) begin
      vld       <= '0;
      res_valid <= 1'b0;
    end else if (en) begin
      vld       <= {vld[STEPS-1:0], job_valid};
      res_valid <= vld[STEPS];
    end
  end

  // advance payload
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i <= STEPS; i++) begin
        stg[i] <= nxt[i];
      end
      res <= res_next;
    end
  end

endmodule

@@ rtl/segment_plane_intersection.sv @@
// Segment against plane crossing test, signed fixed point, one word per cycle unless
// the result channel stalls. Depth: 40 register stages (5 classifier stages, 1 queue
// slot, 1 divider load stage, 32 quotient stages, output register with offset and clamp
// in front of it).
// Throughput: one segment per cycle when not stalled; the quotient digit per stage per axis sets depth.
// Reset: synchronous, clears all valid bits and the queue; plane registers reload.
module segment_plane_intersection #(
  parameter int FRAC_BITS = 16
) (
  input  logic                      clk,
  input  logic                      rst,
  spi_seg_if.sink                   seg_in,
  spi_res_if.source                 res,
  input  logic                      cfg_we,
  input  logic [2:0]                cfg_index,
  input  logic [spi_pkg::CW-1:0]    cfg_data
);
  import spi_pkg::*;

  logic signed [CW-1:0] plane_a, plane_b, plane_c, plane_d;
  logic [LIM_W-1:0]     parallel_limit;
  logic [LIM2_W-1:0]    lim2;
  plane_cfg_t           cfg;

  logic job_valid, job_ready;
  job_t job;
  logic q_valid, q_ready;
  job_t q_job;

  // configuration writes; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      plane_a        <= '0;
      plane_b        <= '0;
      plane_c        <= CW'(65536);
      plane_d        <= '0;
      parallel_limit <= LIM_W'(66);
      lim2           <= LIM2_W'(66 * 66);
    end else begin
      lim2 <= LIM2_W'(parallel_limit) * LIM2_W'(parallel_limit);
      if (cfg_we) begin
        case (cfg_index)
          REG_PLANE_A:   plane_a        <= cfg_data;
          REG_PLANE_B:   plane_b        <= cfg_data;
          REG_PLANE_C:   plane_c        <= cfg_data;
          REG_PLANE_D:   plane_d        <= cfg_data;
          REG_PAR_LIMIT: parallel_limit <= cfg_data[LIM_W-1:0];
          default: ;
        endcase
      end
    end
  end

  assign cfg.a    = plane_a;
  assign cfg.b    = plane_b;
  assign cfg.c    = plane_c;
  assign cfg.d    = plane_d;
  assign cfg.lim2 = lim2;

  spi_front #(
    .FRAC_BITS (FRAC_BITS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (seg_in.valid),
    .in_ready  (seg_in.ready),
    .in_data   (seg_in.data),
    .job_valid (job_valid),
    .job_ready (job_ready),
    .job       (job)
  );

  spi_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (job_valid),
    .push_ready (job_ready),
    .push_data  (job),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_data   (q_job)
  );

  spi_back u_back (
    .clk       (clk),
    .rst       (rst),
    .job_valid (q_valid),
    .job_ready (q_ready),
    .job       (q_job),
    .res_valid (res.valid),
    .res_ready (res.ready),
    .res       (res.data)
  );

  // point fields are zero unless the segment crosses
  assert property (@(posedge clk) disable iff (rst)
    res.valid && (res.data.status != ST_HIT) |->
      (res.data.hit_x == '0) && (res.data.hit_y == '0) && (res.data.hit_z == '0))
    else $error("point fields set on a result that is not a crossing");

  // only defined status codes leave the block
  assert property (@(posedge clk) disable iff (rst)
    res.valid |-> (res.data.status == ST_HIT) || (res.data.status == ST_SIDE) ||
                  (res.data.status == ST_PARALLEL))
    else $error("undefined status code on result");

  // no result straight after reset
  assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> !res.valid)
    else $error("result valid directly after reset");

endmodule
